// ===== src/mau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mau_pkg;

  localparam int VALUE_BITS_DEF = 8;

  // microprogram address width
  localparam int PC_W = 5;

  // datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_RED_A     = 5'd1;
  localparam logic [OP_W-1:0] OP_TAKE_A    = 5'd2;
  localparam logic [OP_W-1:0] OP_TAKE_B    = 5'd3;
  localparam logic [OP_W-1:0] OP_MUL_STEP  = 5'd4;
  localparam logic [OP_W-1:0] OP_MUL_AB    = 5'd5;
  localparam logic [OP_W-1:0] OP_MUL_INV   = 5'd6;
  localparam logic [OP_W-1:0] OP_SRCH_A    = 5'd7;
  localparam logic [OP_W-1:0] OP_SRCH_B    = 5'd8;
  localparam logic [OP_W-1:0] OP_SRCH_STEP = 5'd9;
  localparam logic [OP_W-1:0] OP_ADD       = 5'd10;
  localparam logic [OP_W-1:0] OP_SUB       = 5'd11;
  localparam logic [OP_W-1:0] OP_RES_ACC   = 5'd12;
  localparam logic [OP_W-1:0] OP_RES_INV   = 5'd13;
  localparam logic [OP_W-1:0] OP_FAIL_INV  = 5'd14;
  localparam logic [OP_W-1:0] OP_FAIL_DIV0 = 5'd15;
  localparam logic [OP_W-1:0] OP_RES_ZERO  = 5'd16;

  // jump conditions
  localparam int CND_W = 3;
  localparam logic [CND_W-1:0] C_NEVER     = 3'd0;
  localparam logic [CND_W-1:0] C_ALWAYS    = 3'd1;
  localparam logic [CND_W-1:0] C_BITS_LEFT = 3'd2;
  localparam logic [CND_W-1:0] C_B_ZERO    = 3'd3;
  localparam logic [CND_W-1:0] C_LOOP      = 3'd4;
  localparam logic [CND_W-1:0] C_HIT       = 3'd5;
  localparam logic [CND_W-1:0] C_DISPATCH  = 3'd6;

  // item modes
  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_INV = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_NOINV = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cond;
    logic [PC_W-1:0]  target;
    logic             done;
  } ctrl_t;

  typedef struct packed {
    logic       bits_left;
    logic       b_zero;
    logic       loop;
    logic       hit;
    logic [2:0] mode;
  } flags_t;

endpackage

`default_nettype wire

// ===== src/mau_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mau_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            hold,
  input  wire mau_pkg::flags_t flags,
  output mau_pkg::ctrl_t       cw,
  output logic                 busy
);

  logic [mau_pkg::PC_W-1:0] pc;
  logic [mau_pkg::PC_W-1:0] pc_next;
  logic [mau_pkg::PC_W-1:0] pc_inc;

  function automatic mau_pkg::ctrl_t mk(input logic [mau_pkg::OP_W-1:0] op,
                                        input logic [mau_pkg::CND_W-1:0] cond,
                                        input logic [mau_pkg::PC_W-1:0] target,
                                        input logic done);
    mau_pkg::ctrl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.done   = done;
    return w;
  endfunction

  // microprogram
  function automatic mau_pkg::ctrl_t ucode(input logic [mau_pkg::PC_W-1:0] addr);
    mau_pkg::ctrl_t w;
    unique case (addr)
      5'd0:  w = mk(mau_pkg::OP_RED_A,     mau_pkg::C_NEVER,     5'd0,  1'b0);
      5'd1:  w = mk(mau_pkg::OP_MUL_STEP,  mau_pkg::C_BITS_LEFT, 5'd1,  1'b0);
      5'd2:  w = mk(mau_pkg::OP_TAKE_A,    mau_pkg::C_NEVER,     5'd0,  1'b0);
      5'd3:  w = mk(mau_pkg::OP_MUL_STEP,  mau_pkg::C_BITS_LEFT, 5'd3,  1'b0);
      5'd4:  w = mk(mau_pkg::OP_TAKE_B,    mau_pkg::C_DISPATCH,  5'd0,  1'b0);
      // add, subtract
      5'd5:  w = mk(mau_pkg::OP_ADD,       mau_pkg::C_NEVER,     5'd0,  1'b1);
      5'd6:  w = mk(mau_pkg::OP_SUB,       mau_pkg::C_NEVER,     5'd0,  1'b1);
      // multiply
      5'd7:  w = mk(mau_pkg::OP_MUL_AB,    mau_pkg::C_NEVER,     5'd0,  1'b0);
      5'd8:  w = mk(mau_pkg::OP_MUL_STEP,  mau_pkg::C_BITS_LEFT, 5'd8,  1'b0);
      5'd9:  w = mk(mau_pkg::OP_RES_ACC,   mau_pkg::C_NEVER,     5'd0,  1'b1);
      // divide
      5'd10: w = mk(mau_pkg::OP_SRCH_B,    mau_pkg::C_B_ZERO,    5'd22, 1'b0);
      5'd11: w = mk(mau_pkg::OP_SRCH_STEP, mau_pkg::C_LOOP,      5'd11, 1'b0);
      5'd12: w = mk(mau_pkg::OP_NOP,       mau_pkg::C_HIT,       5'd14, 1'b0);
      5'd13: w = mk(mau_pkg::OP_FAIL_INV,  mau_pkg::C_NEVER,     5'd0,  1'b1);
      5'd14: w = mk(mau_pkg::OP_MUL_INV,   mau_pkg::C_NEVER,     5'd0,  1'b0);
      5'd15: w = mk(mau_pkg::OP_MUL_STEP,  mau_pkg::C_BITS_LEFT, 5'd15, 1'b0);
      5'd16: w = mk(mau_pkg::OP_RES_ACC,   mau_pkg::C_NEVER,     5'd0,  1'b1);
      // inverse
      5'd17: w = mk(mau_pkg::OP_SRCH_A,    mau_pkg::C_NEVER,     5'd0,  1'b0);
      5'd18: w = mk(mau_pkg::OP_SRCH_STEP, mau_pkg::C_LOOP,      5'd18, 1'b0);
      5'd19: w = mk(mau_pkg::OP_NOP,       mau_pkg::C_HIT,       5'd21, 1'b0);
      5'd20: w = mk(mau_pkg::OP_FAIL_INV,  mau_pkg::C_NEVER,     5'd0,  1'b1);
      5'd21: w = mk(mau_pkg::OP_RES_INV,   mau_pkg::C_NEVER,     5'd0,  1'b1);
      // divisor zero
      5'd22: w = mk(mau_pkg::OP_FAIL_DIV0, mau_pkg::C_NEVER,     5'd0,  1'b1);
      // unused modes and spare addresses
      default: w = mk(mau_pkg::OP_RES_ZERO, mau_pkg::C_NEVER,    5'd0,  1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [mau_pkg::PC_W-1:0] dispatch(input logic [2:0] mode);
    logic [mau_pkg::PC_W-1:0] t;
    unique case (mode)
      mau_pkg::MODE_ADD: t = 5'd5;
      mau_pkg::MODE_SUB: t = 5'd6;
      mau_pkg::MODE_MUL: t = 5'd7;
      mau_pkg::MODE_DIV: t = 5'd10;
      mau_pkg::MODE_INV: t = 5'd17;
      default:           t = 5'd23;
    endcase
    return t;
  endfunction

  assign cw     = ucode(pc);
  assign pc_inc = pc + 1'b1;

  always_comb begin
    unique case (cw.cond)
      mau_pkg::C_NEVER:     pc_next = pc_inc;
      mau_pkg::C_ALWAYS:    pc_next = cw.target;
      mau_pkg::C_BITS_LEFT: pc_next = flags.bits_left ? cw.target : pc_inc;
      mau_pkg::C_B_ZERO:    pc_next = flags.b_zero ? cw.target : pc_inc;
      mau_pkg::C_LOOP:      pc_next = flags.loop ? cw.target : pc_inc;
      mau_pkg::C_HIT:       pc_next = flags.hit ? cw.target : pc_inc;
      mau_pkg::C_DISPATCH:  pc_next = dispatch(flags.mode);
      default:              pc_next = pc_inc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (busy && !hold) begin
      if (cw.done) begin
        busy <= 1'b0;
      end else begin
        pc <= pc_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mau_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mau_dp #(
  parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  start,
  input  wire logic                  exec,
  input  wire logic [2:0]            mode_in,
  input  wire logic [VALUE_BITS-1:0] a_in,
  input  wire logic [VALUE_BITS-1:0] b_in,
  input  wire logic [VALUE_BITS:0]   n,
  input  wire mau_pkg::ctrl_t        cw,
  output mau_pkg::flags_t            flags,
  output logic [VALUE_BITS-1:0]      res,
  output logic [1:0]                 st
);

  localparam int W    = VALUE_BITS;
  localparam int BC_W = (W > 2) ? $clog2(W) : 1;

  localparam logic [W-1:0]    ONE      = {{(W-1){1'b0}}, 1'b1};
  localparam logic [BC_W-1:0] LAST_BIT = BC_W'(W - 1);

  logic [2:0]      mode_r;
  logic [W-1:0]    ra;
  logic [W-1:0]    rb;
  logic [W-1:0]    mx;
  logic [W-1:0]    sh;
  logic [W-1:0]    acc;
  logic [W:0]      ri;
  logic [BC_W-1:0] bcnt;

  logic [W:0]   dbl;
  logic [W-1:0] dbl_red;
  logic [W-1:0] mul_next;
  logic [W-1:0] srch_next;
  logic [W:0]   ri_inc;
  logic [W:0]   sub_wrap;
  logic         hit;

  // (x + y) mod m for x, y below m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= m) ? W'(s - m) : W'(s);
  endfunction

  // one bit of interleaved multiply: acc = 2*acc + bit*mx, reduced
  assign dbl       = {acc, 1'b0};
  assign dbl_red   = (dbl >= n) ? W'(dbl - n) : W'(dbl);
  assign mul_next  = add_mod(dbl_red, sh[W-1] ? mx : '0, n);
  assign srch_next = add_mod(acc, mx, n);
  assign ri_inc    = ri + 1'b1;
  assign sub_wrap  = {1'b0, ra} + n - {1'b0, rb};
  assign hit       = (acc == ONE);

  assign flags.bits_left = (bcnt != LAST_BIT);
  assign flags.b_zero    = (rb == '0);
  assign flags.hit       = hit;
  assign flags.loop      = !hit && (ri_inc != n);
  assign flags.mode      = mode_r;

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode_in;
      ra     <= a_in;
      rb     <= b_in;
    end else if (exec) begin
      unique case (cw.op)
        mau_pkg::OP_RED_A: begin
          mx   <= ONE;
          sh   <= ra;
          acc  <= '0;
          bcnt <= '0;
        end
        mau_pkg::OP_TAKE_A: begin
          ra   <= acc;
          mx   <= ONE;
          sh   <= rb;
          acc  <= '0;
          bcnt <= '0;
        end
        mau_pkg::OP_TAKE_B: begin
          rb <= acc;
        end
        mau_pkg::OP_MUL_STEP: begin
          acc  <= mul_next;
          sh   <= {sh[W-2:0], 1'b0};
          bcnt <= bcnt + 1'b1;
        end
        mau_pkg::OP_MUL_AB: begin
          mx   <= ra;
          sh   <= rb;
          acc  <= '0;
          bcnt <= '0;
        end
        mau_pkg::OP_MUL_INV: begin
          mx   <= ra;
          sh   <= ri[W-1:0];
          acc  <= '0;
          bcnt <= '0;
        end
        mau_pkg::OP_SRCH_A: begin
          mx  <= ra;
          acc <= '0;
          ri  <= '0;
        end
        mau_pkg::OP_SRCH_B: begin
          mx  <= rb;
          acc <= '0;
          ri  <= '0;
        end
        mau_pkg::OP_SRCH_STEP: begin
          // candidate frozen once it hits
          if (!hit) begin
            acc <= srch_next;
            ri  <= ri_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res = '0;
    st  = mau_pkg::ST_OK;
    unique case (cw.op)
      mau_pkg::OP_ADD:       res = add_mod(ra, rb, n);
      mau_pkg::OP_SUB:       res = (ra >= rb) ? (ra - rb) : sub_wrap[W-1:0];
      mau_pkg::OP_RES_ACC:   res = acc;
      mau_pkg::OP_RES_INV:   res = ri[W-1:0];
      mau_pkg::OP_FAIL_INV:  st  = mau_pkg::ST_NOINV;
      mau_pkg::OP_FAIL_DIV0: st  = mau_pkg::ST_DIV0;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/modular_arithmetic_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// timing: multiply, inverse and divide results are paced by the shift-and-reduce
//   unit (one operand bit a cycle) and the candidate search (one candidate a cycle)
// throughput: one item at a time, next input beat taken the cycle after the result
//   moves into the output register
// reset: rst synchronous active high, clears the sequencer and output valid, modulus 2

module modular_arithmetic_unit #(
  parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // input beats
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // mode [2:0], operand_a [W+2:3], operand_b [2W+2:W+3], zero fill
  input  wire logic [((3 + 2*VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // result beats
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // result [W-1:0], status [W+1:W], zero fill
  output logic [((VALUE_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
  // modulus register
  input  wire logic              cfg_we,
  input  wire logic [VALUE_BITS:0] cfg_wdata
);

  localparam int W = VALUE_BITS;

  localparam logic [W:0] N_MIN = (W + 1)'(2);
  localparam logic [W:0] N_MAX = {1'b1, {W{1'b0}}};

  // ring size, clamped on write
  logic [W:0] modulus;

  logic           start;
  logic           hold;
  logic           busy;
  logic           out_load;
  mau_pkg::ctrl_t cw;
  mau_pkg::flags_t flags;

  logic [W-1:0] res_val;
  logic [1:0]   st_val;
  logic [W-1:0] result;
  logic [1:0]   status;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= N_MIN;
    end else if (cfg_we) begin
      priority if (cfg_wdata < N_MIN) begin
        modulus <= N_MIN;
      end else if (cfg_wdata > N_MAX) begin
        modulus <= N_MAX;
      end else begin
        modulus <= cfg_wdata;
      end
    end
  end

  // a new item enters only while the sequencer is free; the output register
  // lets it start while the previous result still waits
  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;

  // final microstep waits here until the output register has room
  assign hold     = cw.done && m_tvalid && !m_tready;
  assign out_load = busy && cw.done && !hold;

  mau_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .hold  (hold),
    .flags (flags),
    .cw    (cw),
    .busy  (busy)
  );

  mau_dp #(
    .VALUE_BITS (W)
  ) u_dp (
    .clk     (clk),
    .start   (start),
    .exec    (busy),
    .mode_in (s_tdata[2:0]),
    .a_in    (s_tdata[W+2:3]),
    .b_in    (s_tdata[2*W+2:W+3]),
    .n       (modulus),
    .cw      (cw),
    .flags   (flags),
    .res     (res_val),
    .st      (st_val)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= res_val;
      status <= st_val;
    end
  end

  always_comb begin
    m_tdata          = '0;
    m_tdata[W-1:0]   = result;
    m_tdata[W+1:W]   = status;
  end

endmodule

`default_nettype wire

// ===== src/mau_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mau_check #(
  parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((VALUE_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int W = VALUE_BITS;

  // one item in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // error status carries a zero result and a legal code
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[W+1:W] != mau_pkg::ST_OK) |->
      (m_tdata[W-1:0] == '0 &&
       (m_tdata[W+1:W] == mau_pkg::ST_DIV0 || m_tdata[W+1:W] == mau_pkg::ST_NOINV)))
    else $error("bad error result");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind modular_arithmetic_unit mau_check #(
  .VALUE_BITS (VALUE_BITS)
) u_mau_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/mau_checker.sv =====
`timescale 1ns / 1ps

module mau_checker #(
  parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          s_tvalid,
  input  wire logic                                          s_tready,
  input  wire logic [((3 + 2*VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  wire logic                                          m_tvalid,
  input  wire logic                                          m_tready,
  input  wire logic [((VALUE_BITS + 2 + 7) / 8) * 8 - 1:0]   m_tdata,
  input  wire logic                                          cfg_we,
  input  wire logic [VALUE_BITS:0]                           cfg_wdata,
  output int                                                 outstanding,
  output int                                                 errors
);

  localparam longint RING_MAX = longint'(1) << VALUE_BITS;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [1:0]            status;
  } outcome_t;

  outcome_t            pending_q[$];
  logic [VALUE_BITS:0] modulus;
  int                  mismatches = 0;

  assign errors = mismatches + outstanding;

  function automatic longint ring_size(input logic [VALUE_BITS:0] m);
    if (m < 2) return 2;
    if (m > RING_MAX) return RING_MAX;
    return longint'(m);
  endfunction

  // least i below n with x*i == 1 mod n, -1 when there is none
  function automatic longint mod_inverse(input longint x, input longint n);
    for (longint i = 0; i < n; i++) begin
      if ((x * i) % n == 1) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t mod_outcome(input logic [2:0] mode,
                                           input logic [VALUE_BITS-1:0] a_raw,
                                           input logic [VALUE_BITS-1:0] b_raw,
                                           input logic [VALUE_BITS:0] m);
    longint   n, a, b, inv;
    outcome_t o;
    n = ring_size(m);
    a = longint'(a_raw) % n;
    b = longint'(b_raw) % n;
    o.value  = '0;
    o.status = mau_pkg::ST_OK;
    case (mode)
      mau_pkg::MODE_ADD: o.value = VALUE_BITS'((a + b) % n);
      mau_pkg::MODE_SUB: o.value = VALUE_BITS'((a + n - b) % n);
      mau_pkg::MODE_MUL: o.value = VALUE_BITS'((a * b) % n);
      mau_pkg::MODE_DIV: begin
        if (b == 0) begin
          o.status = mau_pkg::ST_DIV0;
        end else begin
          inv = mod_inverse(b, n);
          if (inv < 0) o.status = mau_pkg::ST_NOINV;
          else o.value = VALUE_BITS'((a * inv) % n);
        end
      end
      mau_pkg::MODE_INV: begin
        inv = mod_inverse(a, n);
        if (inv < 0) o.status = mau_pkg::ST_NOINV;
        else o.value = VALUE_BITS'(inv);
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      modulus <= (VALUE_BITS + 1)'(2);
      pending_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) modulus <= cfg_wdata;
      if (m_tvalid && m_tready) begin
        got.value  = m_tdata[VALUE_BITS-1:0];
        got.status = m_tdata[VALUE_BITS+1:VALUE_BITS];
        if (pending_q.size() == 0) begin
          $error("result beat with no item outstanding: result %0d status %0d",
                 got.value, got.status);
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          if (got.value !== want.value) begin
            $error("result mismatch: expected %0d, got %0d", want.value, got.value);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_q.push_back(mod_outcome(s_tdata[2:0],
                                        s_tdata[VALUE_BITS+2:3],
                                        s_tdata[2*VALUE_BITS+2:VALUE_BITS+3],
                                        modulus));
      end
      outstanding <= pending_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int W            = mau_pkg::VALUE_BITS_DEF;
  localparam int IN_W         = ((3 + 2*W + 7) / 8) * 8;
  localparam int OUT_W        = ((W + 2 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 1000;
  localparam int DRAIN_CYCLES = 300;

  // modes past inverse do nothing
  localparam logic [2:0] MODE_NOP_FIRST = mau_pkg::MODE_INV + 3'd1;
  localparam logic [2:0] MODE_NOP_LAST  = 3'd7;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we;
  logic [W:0]       cfg_wdata;
  int               outstanding;
  int               errors;
  int               burst_left;
  int               idle_cycles;

  modular_arithmetic_unit #(.VALUE_BITS(W)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mau_checker #(.VALUE_BITS(W)) u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .errors      (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // bursts of back-to-back beats, then a gap of random length
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_item(input logic [2:0] mode, input logic [W-1:0] a,
                           input logic [W-1:0] b);
    s_tdata  <= IN_W'({b, a, mode});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pace();
  endtask

  // register writes only once the block has drained
  task automatic write_modulus(input logic [W:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random(input logic [W:0] modv);
    int         top, a_kind, b_kind;
    logic [2:0] mode;
    logic [W-1:0] a, b;
    top = (modv < 2) ? 1 : (modv > (1 << W)) ? (1 << W) - 1 : int'(modv) - 1;
    if ($urandom_range(0, 9) == 0) mode = 3'($urandom_range(MODE_NOP_FIRST, MODE_NOP_LAST));
    else mode = 3'($urandom_range(mau_pkg::MODE_ADD, mau_pkg::MODE_INV));
    a_kind = $urandom_range(0, 9);
    b_kind = $urandom_range(0, 9);
    // mostly in range, some edges and some unreduced values
    a = (a_kind == 0) ? W'($urandom) : (a_kind == 1) ? W'(top) :
        (a_kind == 2) ? '0 : W'($urandom_range(0, top));
    b = (b_kind == 0) ? W'($urandom) : (b_kind == 1) ? W'(top) :
        (b_kind == 2) ? '0 : W'($urandom_range(0, top));
    send_item(mode, a, b);
  endtask

  // result side: stall patterns, now and then a long hold-off to back up the input
  initial begin
    int kind, span, pattern;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    pattern = 0;
    forever begin
      if (pattern % 40 == 5) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        kind = $urandom_range(0, 3);
        span = $urandom_range(10, 200);
        repeat (span) begin
          case (kind)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
      pattern++;
    end
  end

  // no beat on either side for too long ends the run
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int moduli[$];
    int per_phase;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // modulus still at its reset value of two
    send_item(mau_pkg::MODE_ADD, 1, 1);
    send_item(mau_pkg::MODE_INV, 1, 0);
    send_item(mau_pkg::MODE_DIV, 1, 3);

    // composite ring: divisors and values without inverse
    write_modulus(12);
    send_item(mau_pkg::MODE_ADD, 11, 11);
    send_item(mau_pkg::MODE_SUB, 0, 11);
    send_item(mau_pkg::MODE_MUL, 11, 11);
    send_item(mau_pkg::MODE_DIV, 7, 0);
    send_item(mau_pkg::MODE_DIV, 7, 4);
    send_item(mau_pkg::MODE_DIV, 7, 5);
    send_item(mau_pkg::MODE_INV, 0, 9);
    send_item(mau_pkg::MODE_INV, 6, 0);
    send_item(mau_pkg::MODE_INV, 7, 0);
    send_item(MODE_NOP_FIRST, 255, 255);
    send_item(MODE_NOP_LAST, 200, 1);
    send_item(mau_pkg::MODE_ADD, 200, 255);

    // all ones clamps to the full value range
    write_modulus(511);
    send_item(mau_pkg::MODE_MUL, 255, 255);
    send_item(mau_pkg::MODE_SUB, 0, 255);
    send_item(mau_pkg::MODE_INV, 255, 0);
    send_item(mau_pkg::MODE_DIV, 255, 128);
    send_item(mau_pkg::MODE_DIV, 3, 255);

    // zero clamps up to two
    write_modulus(0);
    send_item(mau_pkg::MODE_SUB, 1, 0);
    send_item(mau_pkg::MODE_INV, 3, 0);
    send_item(3'(MODE_NOP_FIRST + 3'd1), 5, 6);

    moduli = '{256, 7, 2, 12, 97, 3, 511, 60, 1, 251, 16, 0};
    moduli.push_back($urandom_range(2, 1 << W));
    moduli.push_back($urandom_range(0, (1 << (W + 1)) - 1));
    per_phase = RANDOM_ITEMS / moduli.size();
    foreach (moduli[p]) begin
      write_modulus((W + 1)'(moduli[p]));
      repeat (per_phase) send_random((W + 1)'(moduli[p]));
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
